// ----- hdl/owbm_pkg.sv -----
// One-wire bus master: shared types, command codes, register indexes and reset values.
// No dependencies; used by the channel interfaces and the core.
package owbm_pkg;

    localparam int BITS_PER_BYTE_DEF = 8;

    localparam int CFG_IDX_W = 3;
    localparam int TICK_W    = 10;
    localparam int SLOT_W    = 8;
    localparam int SHORT_W   = 6;
    localparam int SAMPLE_W  = 7;
    localparam int BIT_IDX_W = 3;

    typedef logic [1:0]           cmd_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [TICK_W-1:0]    tick_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [SHORT_W-1:0]   short_t;
    typedef logic [SAMPLE_W-1:0]  sample_t;
    typedef logic [7:0]           byte_t;
    typedef logic [BIT_IDX_W-1:0] bit_idx_t;

    localparam cmd_t CMD_TICK  = 2'd0;
    localparam cmd_t CMD_RESET = 2'd1;
    localparam cmd_t CMD_WRITE = 2'd2;
    localparam cmd_t CMD_READ  = 2'd3;

    localparam cfg_idx_t REG_RESET_LOW     = 3'd0;
    localparam cfg_idx_t REG_PRESENCE_WAIT = 3'd1;
    localparam cfg_idx_t REG_RESET_TAIL    = 3'd2;
    localparam cfg_idx_t REG_SLOT          = 3'd3;
    localparam cfg_idx_t REG_SHORT_LOW     = 3'd4;
    localparam cfg_idx_t REG_READ_SAMPLE   = 3'd5;

    localparam tick_t   RESET_LOW_INIT     = 10'd500;
    localparam tick_t   PRESENCE_WAIT_INIT = 10'd80;
    localparam tick_t   RESET_TAIL_INIT    = 10'd420;
    localparam slot_t   SLOT_INIT          = 8'd80;
    localparam short_t  SHORT_LOW_INIT     = 6'd2;
    localparam sample_t READ_SAMPLE_INIT   = 7'd10;

endpackage

// ----- hdl/owbm_if.sv -----
// One-wire bus master: valid/ready channel interfaces for items, results and register writes.
// Depends on owbm_pkg.
interface owbm_item_if;
    import owbm_pkg::*;

    logic  valid;
    logic  ready;
    cmd_t  cmd;
    byte_t tx_byte;
    logic  line_level;

    modport source (output valid, cmd, tx_byte, line_level, input ready);
    modport sink (input valid, cmd, tx_byte, line_level, output ready);
endinterface

interface owbm_result_if;
    import owbm_pkg::*;

    logic  valid;
    logic  ready;
    logic  drive_low;
    logic  busy_res;
    logic  done_res;
    byte_t rx_byte;
    logic  no_presence;

    modport source (output valid, drive_low, busy_res, done_res, rx_byte, no_presence,
                    input ready);
    modport sink (input valid, drive_low, busy_res, done_res, rx_byte, no_presence,
                  output ready);
endinterface

interface owbm_cfg_if;
    import owbm_pkg::*;

    logic     valid;
    logic     ready;
    cfg_idx_t idx;
    tick_t    wdata;

    modport source (output valid, idx, wdata, input ready);
    modport sink (input valid, idx, wdata, output ready);
endinterface

// ----- hdl/one_wire_bus_master_core.sv -----
// One-wire bus master core: reset/presence, byte write and byte read sequencing on tick words.
// Depends on owbm_pkg and the channel interfaces in owbm_if.sv.
//
//   channel  | dir | word
//   ---------+-----+---------------------------------------------------
//   items    | in  | cmd, tx_byte, line_level
//   results  | out | drive_low, busy_res, done_res, rx_byte, no_presence
//   cfg      | in  | idx, wdata (register write, always ready)
//
// Each accepted word yields one result word in the next cycle; a word every cycle while
// results does not stall. The rate is set by the single result register: items is ready
// whenever that register is empty or being taken in the same cycle.
// Reset clears the sequencer and loads the register defaults; no clearing pass.
// A stall on results holds the result register and blocks items only.
module one_wire_bus_master_core
#(
    parameter int BITS_PER_BYTE = owbm_pkg::BITS_PER_BYTE_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    owbm_item_if.sink     items,
    owbm_result_if.source results,
    owbm_cfg_if.sink      cfg
);
    import owbm_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_RESET, PH_WRITE, PH_READ} phase_t;
    typedef enum logic [1:0] {RS_LOW, RS_WAIT, RS_TAIL} rst_stage_t;

    localparam bit_idx_t LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

    tick_t   reset_low_reg, presence_wait_reg, reset_tail_reg;
    slot_t   slot_reg;
    short_t  short_low_reg;
    sample_t read_sample_reg;

    phase_t     phase_reg, phase_next;
    rst_stage_t rst_stage_reg, rst_stage_next;
    tick_t      tick_count_reg, tick_count_next;
    bit_idx_t   bit_index_reg, bit_index_next;
    byte_t      shift_data_reg, shift_data_next;
    logic       presence_flag_reg, presence_flag_next;
    byte_t      rx_last_reg, rx_last_next;
    logic       drive_reg, drive_next;
    logic       done_reg, done_next;
    logic       out_valid_reg;

    logic  accept;
    slot_t slot_eff, short_clip, low_one, low_zero, sample_sum, sample_clip, sample_pt;
    tick_t tick_inc;

    assign accept = items.valid && items.ready;
    assign items.ready = !out_valid_reg || results.ready;
    assign cfg.ready = 1'b1;
    assign results.valid = out_valid_reg;

    assign slot_eff    = (slot_reg == '0) ? SLOT_W'(1) : slot_reg;
    assign short_clip  = ({2'b00, short_low_reg} < slot_eff) ? {2'b00, short_low_reg} : slot_eff;
    assign low_one     = short_clip;
    assign low_zero    = slot_eff - short_clip;
    assign sample_sum  = {2'b00, short_low_reg} + {1'b0, read_sample_reg};
    assign sample_clip = (sample_sum > slot_eff) ? slot_eff : sample_sum;
    assign sample_pt   = (sample_clip == '0) ? SLOT_W'(1) : sample_clip;
    assign tick_inc    = tick_count_reg + TICK_W'(1);

    always_comb
    begin
        phase_next         = phase_reg;
        rst_stage_next     = rst_stage_reg;
        tick_count_next    = tick_count_reg;
        bit_index_next     = bit_index_reg;
        shift_data_next    = shift_data_reg;
        presence_flag_next = presence_flag_reg;
        rx_last_next       = rx_last_reg;
        drive_next         = drive_reg;
        done_next          = 1'b0;

        if (items.cmd != CMD_TICK)
        begin
            if (phase_reg == PH_IDLE)
            begin
                tick_count_next = '0;
                bit_index_next  = '0;
                case (items.cmd)
                    CMD_RESET:
                    begin
                        phase_next     = PH_RESET;
                        rst_stage_next = RS_LOW;
                        drive_next     = 1'b1;
                    end
                    CMD_WRITE:
                    begin
                        phase_next      = PH_WRITE;
                        shift_data_next = items.tx_byte;
                        drive_next      = items.tx_byte[0] ? (low_one != '0) : (low_zero != '0);
                    end
                    default:
                    begin
                        phase_next      = PH_READ;
                        shift_data_next = '0;
                        drive_next      = (low_one != '0);
                    end
                endcase
            end
        end
        else
        begin
            case (phase_reg)
                PH_RESET:
                begin
                    tick_count_next = tick_inc;
                    case (rst_stage_reg)
                        RS_LOW:
                        begin
                            if (tick_inc >= reset_low_reg)
                            begin
                                rst_stage_next  = RS_WAIT;
                                tick_count_next = '0;
                                drive_next      = 1'b0;
                            end
                        end
                        RS_WAIT:
                        begin
                            if (tick_inc >= presence_wait_reg)
                            begin
                                presence_flag_next = items.line_level;
                                rst_stage_next     = RS_TAIL;
                                tick_count_next    = '0;
                            end
                        end
                        default:
                        begin
                            if (tick_inc >= reset_tail_reg)
                            begin
                                phase_next      = PH_IDLE;
                                rst_stage_next  = RS_LOW;
                                tick_count_next = '0;
                                drive_next      = 1'b0;
                                done_next       = 1'b1;
                            end
                        end
                    endcase
                end
                PH_WRITE:
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= {2'b00, slot_eff})
                    begin
                        tick_count_next = '0;
                        if (bit_index_reg >= LAST_BIT)
                        begin
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            bit_index_next  = bit_index_reg + BIT_IDX_W'(1);
                            shift_data_next = {1'b0, shift_data_reg[7:1]};
                        end
                    end
                    drive_next = (phase_next == PH_WRITE) &&
                                 (tick_count_next < {2'b00,
                                  (shift_data_next[0] ? low_one : low_zero)});
                end
                PH_READ:
                begin
                    tick_count_next = tick_inc;
                    if ((tick_inc == {2'b00, sample_pt}) && items.line_level)
                    begin
                        shift_data_next[bit_index_reg] = 1'b1;
                    end
                    if (tick_inc >= {2'b00, slot_eff})
                    begin
                        tick_count_next = '0;
                        if (bit_index_reg >= LAST_BIT)
                        begin
                            rx_last_next = shift_data_next;
                            phase_next   = PH_IDLE;
                            done_next    = 1'b1;
                        end
                        else
                        begin
                            bit_index_next = bit_index_reg + BIT_IDX_W'(1);
                        end
                    end
                    drive_next = (phase_next == PH_READ) &&
                                 (tick_count_next < {2'b00, low_one});
                end
                default:
                begin
                    drive_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_low_reg     <= RESET_LOW_INIT;
            presence_wait_reg <= PRESENCE_WAIT_INIT;
            reset_tail_reg    <= RESET_TAIL_INIT;
            slot_reg          <= SLOT_INIT;
            short_low_reg     <= SHORT_LOW_INIT;
            read_sample_reg   <= READ_SAMPLE_INIT;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.idx)
                REG_RESET_LOW:     reset_low_reg     <= cfg.wdata;
                REG_PRESENCE_WAIT: presence_wait_reg <= cfg.wdata;
                REG_RESET_TAIL:    reset_tail_reg    <= cfg.wdata;
                REG_SLOT:          slot_reg          <= cfg.wdata[SLOT_W-1:0];
                REG_SHORT_LOW:     short_low_reg     <= cfg.wdata[SHORT_W-1:0];
                REG_READ_SAMPLE:   read_sample_reg   <= cfg.wdata[SAMPLE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            rst_stage_reg     <= RS_LOW;
            tick_count_reg    <= '0;
            bit_index_reg     <= '0;
            shift_data_reg    <= '0;
            presence_flag_reg <= 1'b0;
            rx_last_reg       <= '0;
            drive_reg         <= 1'b0;
            done_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg         <= phase_next;
                rst_stage_reg     <= rst_stage_next;
                tick_count_reg    <= tick_count_next;
                bit_index_reg     <= bit_index_next;
                shift_data_reg    <= shift_data_next;
                presence_flag_reg <= presence_flag_next;
                rx_last_reg       <= rx_last_next;
                drive_reg         <= drive_next;
                done_reg          <= done_next;
                out_valid_reg     <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.drive_low   = drive_reg;
    assign results.busy_res    = (phase_reg != PH_IDLE);
    assign results.done_res    = done_reg;
    assign results.rx_byte     = rx_last_reg;
    assign results.no_presence = presence_flag_reg;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for one_wire_bus_master_core: directed and random tick/command words on the item channel,
// register writes between phases, every result word checked against a built-in bus master predictor.
// Depends on owbm_pkg and the channel interfaces in hdl/owbm_if.sv.

import owbm_pkg::*;

typedef struct packed {
    logic  drive_low;
    logic  busy;
    logic  done;
    byte_t rx;
    logic  no_presence;
} bus_word_t;

typedef struct packed {
    cfg_idx_t idx;
    tick_t    data;
} cfg_word_t;

class bus_master_scoreboard;
    typedef enum logic [1:0] {LINK_IDLE, LINK_RESET, LINK_WRITE, LINK_READ} link_phase_e;

    tick_t       rst_low;
    tick_t       pres_wait;
    tick_t       rst_tail;
    slot_t       slot;
    short_t      pulse_len;
    sample_t     sample_dly;
    link_phase_e phase;
    int unsigned ticks;
    int unsigned bit_pos;
    int unsigned rst_stage;
    byte_t       shreg;
    byte_t       rx_last;
    logic        presence;
    logic        drive;
    bus_word_t   pending_words[$];
    int          errors;

    function new();
        rst_low    = RESET_LOW_INIT;
        pres_wait  = PRESENCE_WAIT_INIT;
        rst_tail   = RESET_TAIL_INIT;
        slot       = SLOT_INIT;
        pulse_len  = SHORT_LOW_INIT;
        sample_dly = READ_SAMPLE_INIT;
        phase      = LINK_IDLE;
        ticks      = 0;
        bit_pos    = 0;
        rst_stage  = 0;
        shreg      = '0;
        rx_last    = '0;
        presence   = 1'b0;
        drive      = 1'b0;
        errors     = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, tick_t data);
        case (idx)
            REG_RESET_LOW:     rst_low = data;
            REG_PRESENCE_WAIT: pres_wait = data;
            REG_RESET_TAIL:    rst_tail = data;
            REG_SLOT:          slot = data[SLOT_W-1:0];
            REG_SHORT_LOW:     pulse_len = data[SHORT_W-1:0];
            REG_READ_SAMPLE:   sample_dly = data[SAMPLE_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned slot_len();
        return (slot == 0) ? 1 : slot;
    endfunction

    function int unsigned low_len(logic one);
        int unsigned s;
        int unsigned l;
        s = slot_len();
        l = (pulse_len < s) ? pulse_len : s;
        return one ? l : s - l;
    endfunction

    function int unsigned sample_point();
        int unsigned s;
        int unsigned p;
        s = slot_len();
        p = pulse_len + sample_dly;
        if (p > s)
            p = s;
        if (p == 0)
            p = 1;
        return p;
    endfunction

    function bit op_active();
        return phase != LINK_IDLE;
    endfunction

    function int outstanding();
        return pending_words.size();
    endfunction

    function void note_item(cmd_t c, byte_t b, logic line);
        bit        done;
        bit        last;
        bus_word_t w;
        done = 1'b0;
        last = (bit_pos + 1 >= BITS_PER_BYTE_DEF);
        if (c != CMD_TICK) begin
            if (phase == LINK_IDLE) begin
                ticks   = 0;
                bit_pos = 0;
                if (c == CMD_RESET) begin
                    phase     = LINK_RESET;
                    rst_stage = 0;
                    drive     = 1'b1;
                end else if (c == CMD_WRITE) begin
                    phase = LINK_WRITE;
                    shreg = b;
                    drive = low_len(shreg[0]) > 0;
                end else begin
                    phase = LINK_READ;
                    shreg = '0;
                    drive = low_len(1'b1) > 0;
                end
            end
        end else begin
            case (phase)
                LINK_RESET: begin
                    ticks++;
                    if (rst_stage == 0) begin
                        if (ticks >= rst_low) begin
                            rst_stage = 1;
                            ticks     = 0;
                            drive     = 1'b0;
                        end
                    end else if (rst_stage == 1) begin
                        if (ticks >= pres_wait) begin
                            presence  = line;
                            rst_stage = 2;
                            ticks     = 0;
                        end
                    end else if (ticks >= rst_tail) begin
                        phase     = LINK_IDLE;
                        rst_stage = 0;
                        ticks     = 0;
                        drive     = 1'b0;
                        done      = 1'b1;
                    end
                end
                LINK_WRITE: begin
                    ticks++;
                    if (ticks >= slot_len()) begin
                        ticks = 0;
                        if (last) begin
                            phase = LINK_IDLE;
                            done  = 1'b1;
                        end else begin
                            bit_pos = (bit_pos + 1) % 8;
                            shreg   = shreg >> 1;
                        end
                    end
                    drive = (phase == LINK_WRITE) && (ticks < low_len(shreg[0]));
                end
                LINK_READ: begin
                    ticks++;
                    if (ticks == sample_point() && line)
                        shreg[bit_pos % 8] = 1'b1;
                    if (ticks >= slot_len()) begin
                        ticks = 0;
                        if (last) begin
                            rx_last = shreg;
                            phase   = LINK_IDLE;
                            done    = 1'b1;
                        end else begin
                            bit_pos = (bit_pos + 1) % 8;
                        end
                    end
                    drive = (phase == LINK_READ) && (ticks < low_len(1'b1));
                end
                default: drive = 1'b0;
            endcase
        end
        w.drive_low   = drive;
        w.busy        = (phase != LINK_IDLE);
        w.done        = done;
        w.rx          = rx_last;
        w.no_presence = presence;
        pending_words.push_back(w);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_word(bus_word_t got);
        bus_word_t want;
        if (pending_words.size() == 0) begin
            $error("result word with no expectation waiting");
            errors++;
            return;
        end
        want = pending_words.pop_front();
        compare_field("drive_low", want.drive_low, got.drive_low);
        compare_field("busy_res", want.busy, got.busy);
        compare_field("done_res", want.done, got.done);
        compare_field("rx_byte", want.rx, got.rx);
        compare_field("no_presence", want.no_presence, got.no_presence);
    endfunction

    function void close();
        if (pending_words.size() != 0) begin
            $error("%0d expected result words never arrived", pending_words.size());
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 12;
    localparam int RANDOM_ITEMS  = 500;
    localparam int STALL_CYCLES  = 400;
    localparam int DEFAULT_TICKS = 100;
    localparam int LARGE_TICKS   = 300;
    localparam int PEEK_TICKS    = 40;

    localparam int LINE_LOW    = 0;
    localparam int LINE_HIGH   = 1;
    localparam int LINE_RANDOM = 2;

    localparam cfg_idx_t REG_SPARE_LO = cfg_idx_t'(REG_READ_SAMPLE + 1);
    localparam cfg_idx_t REG_SPARE_HI = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_hold;
    logic quiet;
    int unsigned cycle_count = 0;
    int counted_items;
    cfg_word_t cfg_batch[$];
    bus_master_scoreboard sb;

    owbm_item_if   item_ch();
    owbm_result_if result_ch();
    owbm_cfg_if    cfg_ch();

    one_wire_bus_master_core #(.BITS_PER_BYTE(BITS_PER_BYTE_DEF)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        bus_word_t got;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.drive_low   = result_ch.drive_low;
                got.busy        = result_ch.busy_res;
                got.done        = result_ch.done_res;
                got.rx          = result_ch.rx_byte;
                got.no_presence = result_ch.no_presence;
                sb.check_word(got);
            end
            if (sink_hold)
                result_ch.ready <= 1'b0;
            else if (quiet)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic pick_line(int mode);
        if (mode == LINE_LOW)
            return 1'b0;
        if (mode == LINE_HIGH)
            return 1'b1;
        return 1'($urandom_range(1));
    endfunction

    function automatic tick_t with_junk(int unsigned v, int w);
        tick_t keep_mask;
        keep_mask = tick_t'((1 << w) - 1);
        return (tick_t'($urandom) & ~keep_mask) | (tick_t'(v) & keep_mask);
    endfunction

    task automatic stall_sink(int n);
        sink_hold <= 1'b1;
        repeat (n) @(posedge clk);
        sink_hold <= 1'b0;
    endtask

    task automatic send_item(cmd_t c, byte_t b, logic line);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.cmd        <= c;
        item_ch.tx_byte    <= b;
        item_ch.line_level <= line;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (c == CMD_TICK || !sb.op_active())
            counted_items++;
        sb.note_item(c, b, line);
    endtask

    task automatic send_ticks(int n);
        repeat (n)
            send_item(CMD_TICK, byte_t'($urandom), pick_line(LINE_RANDOM));
    endtask

    // start an operation and tick it through to completion
    task automatic run_op(cmd_t c, byte_t b, int mode, bit noisy);
        send_item(c, b, pick_line(mode));
        while (sb.op_active())
        begin
            if (noisy && $urandom_range(99) < 4)
                send_item(cmd_t'($urandom_range(3, 1)), byte_t'($urandom), pick_line(mode));
            else
                send_item(CMD_TICK, byte_t'($urandom), pick_line(mode));
        end
    endtask

    // drop valid and wait for every result word
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // finish any operation, then drain
    task automatic settle();
        while (sb.op_active())
            send_item(CMD_TICK, byte_t'($urandom), pick_line(LINE_RANDOM));
        drain();
    endtask

    task automatic queue_timing(tick_t rl, tick_t pw, tick_t rt, tick_t sl, tick_t pl, tick_t sd);
        cfg_batch.push_back({REG_RESET_LOW, rl});
        cfg_batch.push_back({REG_PRESENCE_WAIT, pw});
        cfg_batch.push_back({REG_RESET_TAIL, rt});
        cfg_batch.push_back({REG_SLOT, sl});
        cfg_batch.push_back({REG_SHORT_LOW, pl});
        cfg_batch.push_back({REG_READ_SAMPLE, sd});
    endtask

    task automatic queue_short_timing();
        queue_timing(10'd3, 10'd2, 10'd2, 10'd6, 10'd1, 10'd2);
    endtask

    task automatic queue_random_timing();
        int unsigned sl;
        sl = $urandom_range(24);
        queue_timing(tick_t'($urandom_range(30)), tick_t'($urandom_range(30)),
                     tick_t'($urandom_range(30)), with_junk(sl, SLOT_W),
                     with_junk($urandom_range(sl + 4), SHORT_W),
                     with_junk($urandom_range(sl + 4), SAMPLE_W));
        if ($urandom_range(3) == 0)
            cfg_batch.push_back({REG_SPARE_LO, tick_t'($urandom)});
    endtask

    task automatic apply_cfg();
        cfg_word_t w;
        while (cfg_batch.size() > 0)
        begin
            w = cfg_batch.pop_front();
            cfg_ch.valid <= 1'b1;
            cfg_ch.idx   <= w.idx;
            cfg_ch.wdata <= w.data;
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            sb.write_reg(w.idx, w.data);
        end
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int phase_no;
        int target;
        int pick;
        sb = new();
        counted_items = 0;
        item_ch.valid      <= 1'b0;
        item_ch.cmd        <= CMD_TICK;
        item_ch.tx_byte    <= '0;
        item_ch.line_level <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.idx         <= REG_RESET_LOW;
        cfg_ch.wdata       <= '0;
        sink_hold          <= 1'b0;
        quiet              <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: idle ticks, the first slots of a write, commands while busy
        send_item(CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_TICK, 8'hFF, 1'b1);
        send_item(CMD_WRITE, 8'hA5, 1'b1);
        send_item(CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_READ, 8'h00, 1'b1);
        send_item(CMD_RESET, 8'hFF, 1'b0);
        send_item(CMD_TICK, 8'h00, 1'b1);
        send_ticks(DEFAULT_TICKS);
        drain();

        queue_short_timing();
        apply_cfg();
        settle();
        run_op(CMD_RESET, 8'h00, LINE_LOW, 1'b0);
        run_op(CMD_RESET, 8'h00, LINE_HIGH, 1'b0);
        run_op(CMD_WRITE, 8'h00, LINE_RANDOM, 1'b0);
        run_op(CMD_WRITE, 8'hFF, LINE_RANDOM, 1'b0);
        run_op(CMD_READ, 8'h00, LINE_HIGH, 1'b0);
        run_op(CMD_READ, 8'h00, LINE_LOW, 1'b0);
        settle();

        // all registers zero, plus writes to unused indexes
        queue_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        cfg_batch.push_back({REG_SPARE_LO, tick_t'($urandom)});
        cfg_batch.push_back({REG_SPARE_HI, tick_t'($urandom)});
        apply_cfg();
        run_op(CMD_RESET, 8'h00, LINE_RANDOM, 1'b0);
        run_op(CMD_WRITE, 8'h80, LINE_RANDOM, 1'b0);
        run_op(CMD_READ, 8'h00, LINE_RANDOM, 1'b0);
        settle();

        // short pulse longer than the slot
        queue_timing(10'd1, 10'd1, 10'd1, 10'd5, 10'd9, 10'd0);
        apply_cfg();
        run_op(CMD_WRITE, 8'h5A, LINE_RANDOM, 1'b0);
        run_op(CMD_READ, 8'h00, LINE_RANDOM, 1'b0);
        settle();

        // sample point past the end of the slot
        queue_timing(10'd2, 10'd1, 10'd3, 10'd6, 10'd2, 10'd20);
        apply_cfg();
        run_op(CMD_READ, 8'h00, LINE_RANDOM, 1'b0);
        run_op(CMD_WRITE, 8'h3C, LINE_RANDOM, 1'b0);
        settle();

        // zero short pulse
        queue_timing(10'd4, 10'd4, 10'd4, 10'd8, 10'd0, 10'd0);
        apply_cfg();
        run_op(CMD_WRITE, 8'h96, LINE_RANDOM, 1'b0);
        run_op(CMD_READ, 8'h00, LINE_RANDOM, 1'b0);
        settle();

        // largest settings: one full read slot, then the start of a reset
        queue_timing(10'd1023, 10'd1023, 10'd1023, 10'd255, 10'd63, 10'd127);
        apply_cfg();
        send_item(CMD_READ, 8'h00, 1'b1);
        send_ticks(LARGE_TICKS);
        drain();
        queue_short_timing();
        apply_cfg();
        settle();
        queue_timing(10'd1023, 10'd1023, 10'd1023, 10'd255, 10'd63, 10'd127);
        apply_cfg();
        send_item(CMD_RESET, 8'h00, 1'b0);
        send_ticks(PEEK_TICKS);
        drain();
        queue_short_timing();
        apply_cfg();
        settle();

        counted_items = 0;
        phase_no = 0;
        while (counted_items < RANDOM_ITEMS)
        begin
            queue_random_timing();
            apply_cfg();
            quiet <= (phase_no == 1);
            if (phase_no == 0)
                fork
                    stall_sink(STALL_CYCLES);
                join_none
            target = counted_items + $urandom_range(200, 100);
            while (counted_items < target)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    run_op(cmd_t'($urandom_range(3, 1)), byte_t'($urandom),
                           $urandom_range(LINE_RANDOM), 1'b1);
                else if (pick < 92)
                    repeat ($urandom_range(4, 1))
                        send_item(CMD_TICK, byte_t'($urandom), pick_line(LINE_RANDOM));
                else
                begin
                    send_item(cmd_t'($urandom_range(3, 1)), byte_t'($urandom),
                              pick_line(LINE_RANDOM));
                    repeat ($urandom_range(5))
                        send_item(CMD_TICK, byte_t'($urandom), pick_line(LINE_RANDOM));
                    send_item(cmd_t'($urandom_range(3, 1)), byte_t'($urandom),
                              pick_line(LINE_RANDOM));
                end
            end
            settle();
            quiet <= 1'b0;
            phase_no++;
        end

        repeat (5) @(posedge clk);
        sb.close();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
